// ===== design/telnet_ansi_line_editor_unit_macros.svh =====
// Assertion macros for the telnet_ansi_line_editor_unit top level.
// They rely on clk and arst_n being visible in the module that uses them.
`ifndef TELNET_ANSI_LINE_EDITOR_UNIT_MACROS_SVH
`define TELNET_ANSI_LINE_EDITOR_UNIT_MACROS_SVH

// Consequent checked in the same cycle.
`define TLAE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TLAE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tlae_pkg.sv =====
// Shared types and defaults for the Telnet/ANSI line editor.
// No dependencies.
package tlae_pkg;

	localparam int LINE_CAPACITY_DEF   = 32;
	localparam int ESCAPE_CAPACITY_DEF = 13;

	typedef enum logic [3:0] {
		K_ECHO    = 4'd0,
		K_FLUSH   = 4'd1,
		K_PROMPT  = 4'd2,
		K_LINE    = 4'd3,
		K_INTR    = 4'd4,
		K_ESCAPE  = 4'd5,
		K_CONTROL = 4'd6,
		K_LDATA   = 4'd7,
		K_EDATA   = 4'd8
	} kind_t;

	// One result from the sequencer toward the output register.
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} emit_t;

endpackage

// ===== design/tlae_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/tlae_ctrl.sv =====
// Byte parser and result sequencer for the line editor.
// Uses tlae_pkg; drives the line and escape RAMs held by the top level.
module tlae_ctrl #(
	parameter int LINE_CAPACITY   = tlae_pkg::LINE_CAPACITY_DEF,
	parameter int ESCAPE_CAPACITY = tlae_pkg::ESCAPE_CAPACITY_DEF,
	localparam int LAW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1,
	localparam int EAW = (ESCAPE_CAPACITY > 1) ? $clog2(ESCAPE_CAPACITY) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                out_free,
	output tlae_pkg::emit_t     emit,
	output logic                lwr_en,
	output logic [LAW-1:0]      lwr_addr,
	output logic [7:0]          lwr_data,
	output logic [LAW-1:0]      lrd_addr,
	input  logic [7:0]          lrd_data,
	output logic                ewr_en,
	output logic [EAW-1:0]      ewr_addr,
	output logic [7:0]          ewr_data,
	output logic [EAW-1:0]      erd_addr,
	input  logic [7:0]          erd_data
);
	import tlae_pkg::*;

	localparam int LCW = $clog2(LINE_CAPACITY + 1);
	localparam int ECW = $clog2(ESCAPE_CAPACITY + 1);
	localparam int IW  = (LCW > ECW) ? LCW : ECW;

	localparam logic [7:0] B_NUL    = 8'h00;
	localparam logic [7:0] B_ETX    = 8'h03;
	localparam logic [7:0] B_BS     = 8'h08;
	localparam logic [7:0] B_LF     = 8'h0A;
	localparam logic [7:0] B_CR     = 8'h0D;
	localparam logic [7:0] B_ESC    = 8'h1B;
	localparam logic [7:0] B_SP     = 8'h20;
	localparam logic [7:0] B_CSI    = 8'h5B;
	localparam logic [7:0] B_FE_LO  = 8'h40;
	localparam logic [7:0] B_FE_HI  = 8'h5E;
	localparam logic [7:0] B_FIN_HI = 8'h7E;
	localparam logic [7:0] B_DEL    = 8'h7F;
	localparam logic [7:0] B_IP     = 8'hF4;
	localparam logic [7:0] B_WILL   = 8'hFB;
	localparam logic [7:0] B_DONT   = 8'hFE;
	localparam logic [7:0] B_IAC    = 8'hFF;

	typedef enum logic [6:0] {
		M_IDLE     = 7'b0000001,
		M_IAC      = 7'b0000010,
		M_IAC_OPT  = 7'b0000100,
		M_AFTER_CR = 7'b0001000,
		M_ESC      = 7'b0010000,
		M_CSI      = 7'b0100000,
		M_FE       = 7'b1000000
	} mode_t;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_CR_HEAD  = 10'b0000000010,
		ST_LDATA    = 10'b0000000100,
		ST_CR_TAIL  = 10'b0000001000,
		ST_INTR     = 10'b0000010000,
		ST_BKSP     = 10'b0000100000,
		ST_CTRL     = 10'b0001000000,
		ST_PRINT    = 10'b0010000000,
		ST_ESC_HEAD = 10'b0100000000,
		ST_EDATA    = 10'b1000000000
	} state_t;

	state_t         st_q, st_d;
	mode_t          mode_q, mode_d;
	logic [1:0]     step_q, step_d;
	logic [LCW-1:0] lcnt_q, lcnt_d;
	logic [ECW-1:0] ecnt_q, ecnt_d;
	logic [7:0]     byte_q, byte_d;
	logic [IW-1:0]  idx_q, idx_nxt;

	// Shared index unit: one incrementer and one compare serve both data runs.
	logic [IW-1:0]  idx_inc;
	logic [IW-1:0]  limit;
	logic           hit;
	logic           interp;

	assign idx_inc  = IW'(idx_q + 1'b1);
	assign limit    = (st_q == ST_EDATA) ? IW'(ecnt_q) : IW'(lcnt_q);
	assign hit      = (idx_inc == limit);
	assign in_ready = (st_q == ST_IDLE);
	assign lrd_addr = idx_nxt[LAW-1:0];
	assign erd_addr = idx_nxt[EAW-1:0];
	assign lwr_addr = lcnt_q[LAW-1:0];
	assign lwr_data = in_byte;
	assign ewr_data = in_byte;

	always_comb begin
		emit    = '{valid: 1'b0, kind: K_ECHO, value: 8'h00, last: 1'b0};
		st_d    = st_q;
		mode_d  = mode_q;
		step_d  = step_q;
		lcnt_d  = lcnt_q;
		ecnt_d  = ecnt_q;
		byte_d  = byte_q;
		idx_nxt = '0;
		lwr_en  = 1'b0;
		ewr_en  = 1'b0;
		ewr_addr = ecnt_q[EAW-1:0];
		interp  = 1'b0;

		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					byte_d = in_byte;
					step_d = 2'd0;
					unique case (mode_q)
						M_IAC: begin
							if (in_byte == B_IP) begin
								st_d   = ST_INTR;
								mode_d = M_IDLE;
							end else if (in_byte >= B_WILL && in_byte <= B_DONT) begin
								mode_d = M_IAC_OPT;
							end else begin
								mode_d = M_IDLE;
							end
						end
						M_IAC_OPT: mode_d = M_IDLE;
						M_AFTER_CR: begin
							if (in_byte == B_NUL) begin
								mode_d = M_IDLE;
							end else begin
								interp = 1'b1;
							end
						end
						M_ESC: begin
							ewr_en   = 1'b1;
							ewr_addr = '0;
							ecnt_d   = ECW'(1);
							if (in_byte == B_CSI) begin
								mode_d = M_CSI;
							end else if (in_byte >= B_FE_LO && in_byte <= B_FE_HI) begin
								mode_d = M_FE;
							end else begin
								mode_d = M_IDLE;
								st_d   = ST_ESC_HEAD;
							end
						end
						M_CSI: begin
							if (ecnt_q < ECW'(ESCAPE_CAPACITY)) begin
								ewr_en = 1'b1;
								ecnt_d = ECW'(ecnt_q + 1'b1);
							end
							if (in_byte >= B_FE_LO && in_byte <= B_FIN_HI) begin
								mode_d = M_IDLE;
								st_d   = ST_ESC_HEAD;
							end
						end
						M_FE: begin
							if (ecnt_q < ECW'(ESCAPE_CAPACITY)) begin
								ewr_en = 1'b1;
								ecnt_d = ECW'(ecnt_q + 1'b1);
							end
							mode_d = M_IDLE;
							st_d   = ST_ESC_HEAD;
						end
						default: interp = 1'b1;
					endcase
				end
			end
			ST_CR_HEAD: begin
				emit.valid = 1'b1;
				unique case (step_q)
					2'd0: emit.kind = K_FLUSH;
					2'd1: begin
						emit.value = B_CR;
					end
					2'd2: begin
						emit.value = B_LF;
					end
					default: begin
						emit.kind  = K_LINE;
						emit.value = 8'(lcnt_q);
					end
				endcase
				if (out_free) begin
					if (step_q == 2'd3) begin
						step_d = 2'd0;
						st_d   = (lcnt_q == '0) ? ST_CR_TAIL : ST_LDATA;
					end else begin
						step_d = step_q + 2'd1;
					end
				end
			end
			ST_LDATA: begin
				emit.valid = 1'b1;
				emit.kind  = K_LDATA;
				emit.value = lrd_data;
				idx_nxt    = idx_q;
				if (out_free) begin
					if (hit) begin
						st_d    = ST_CR_TAIL;
						idx_nxt = '0;
					end else begin
						idx_nxt = idx_inc;
					end
				end
			end
			ST_CR_TAIL: begin
				emit.valid = 1'b1;
				emit.kind  = step_q[0] ? K_PROMPT : K_FLUSH;
				emit.last  = step_q[0];
				if (out_free) begin
					if (step_q[0]) begin
						st_d   = ST_IDLE;
						step_d = 2'd0;
						lcnt_d = '0;
					end else begin
						step_d = 2'd1;
					end
				end
			end
			ST_INTR: begin
				emit.valid = 1'b1;
				emit.kind  = step_q[0] ? K_INTR : K_FLUSH;
				emit.last  = step_q[0];
				if (out_free) begin
					st_d   = step_q[0] ? ST_IDLE : ST_INTR;
					step_d = step_q[0] ? 2'd0 : 2'd1;
				end
			end
			ST_BKSP: begin
				emit.valid = 1'b1;
				emit.value = (step_q == 2'd1) ? B_SP : B_BS;
				emit.last  = (step_q == 2'd2);
				if (out_free) begin
					if (step_q == 2'd2) begin
						st_d   = ST_IDLE;
						step_d = 2'd0;
					end else begin
						step_d = step_q + 2'd1;
					end
				end
			end
			ST_CTRL: begin
				emit.valid = 1'b1;
				emit.kind  = K_CONTROL;
				emit.value = byte_q;
				emit.last  = 1'b1;
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			ST_PRINT: begin
				emit.valid = 1'b1;
				emit.kind  = step_q[0] ? K_ECHO : K_FLUSH;
				emit.value = step_q[0] ? byte_q : 8'h00;
				emit.last  = step_q[0];
				if (out_free) begin
					st_d   = step_q[0] ? ST_IDLE : ST_PRINT;
					step_d = step_q[0] ? 2'd0 : 2'd1;
				end
			end
			ST_ESC_HEAD: begin
				emit.valid = 1'b1;
				emit.kind  = K_ESCAPE;
				emit.value = 8'(ecnt_q);
				emit.last  = (ecnt_q == '0);
				if (out_free) begin
					st_d = (ecnt_q == '0) ? ST_IDLE : ST_EDATA;
				end
			end
			ST_EDATA: begin
				emit.valid = 1'b1;
				emit.kind  = K_EDATA;
				emit.value = erd_data;
				emit.last  = hit;
				idx_nxt    = idx_q;
				if (out_free) begin
					if (hit) begin
						st_d    = ST_IDLE;
						ecnt_d  = '0;
						idx_nxt = '0;
					end else begin
						idx_nxt = idx_inc;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase

		// Ordinary byte handling, shared by idle mode and the byte after CR.
		if (interp) begin
			mode_d = M_IDLE;
			priority if (in_byte == B_IAC) begin
				mode_d = M_IAC;
			end else if (in_byte == B_CR) begin
				st_d   = ST_CR_HEAD;
				mode_d = M_AFTER_CR;
			end else if (in_byte == B_ETX) begin
				st_d = ST_INTR;
			end else if (in_byte == B_DEL) begin
				if (lcnt_q != '0) begin
					st_d   = ST_BKSP;
					lcnt_d = LCW'(lcnt_q - 1'b1);
				end
			end else if (in_byte == B_ESC) begin
				mode_d = M_ESC;
			end else if (in_byte < B_SP) begin
				st_d = ST_CTRL;
			end else begin
				st_d = ST_PRINT;
				if (lcnt_q < LCW'(LINE_CAPACITY)) begin
					lwr_en = 1'b1;
					lcnt_d = LCW'(lcnt_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			mode_q <= M_IDLE;
			step_q <= 2'd0;
			lcnt_q <= '0;
			ecnt_q <= '0;
			idx_q  <= '0;
		end else begin
			st_q   <= st_d;
			mode_q <= mode_d;
			step_q <= step_d;
			lcnt_q <= lcnt_d;
			ecnt_q <= ecnt_d;
			idx_q  <= idx_nxt;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

endmodule

// ===== design/telnet_ansi_line_editor_unit.sv =====
// Telnet/ANSI line editor top level: sequencer, line and escape RAMs, output register.
// Uses tlae_pkg, tlae_ram, tlae_ctrl and the assertion macro header.
// A byte that causes results holds s_tready low until its last one is taken; one causing none
// leaves it high. The sequencer issues one result per cycle into the output register; the first
// result of a byte passes the state and output registers; output stalls pause the sequencer.
// Reset clears parser mode, counts and handshake state at once; RAM contents are not cleared.
`include "telnet_ansi_line_editor_unit_macros.svh"

module telnet_ansi_line_editor_unit #(
	parameter int LINE_CAPACITY   = tlae_pkg::LINE_CAPACITY_DEF,
	parameter int ESCAPE_CAPACITY = tlae_pkg::ESCAPE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_in
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] value
	output logic [3:0] m_tuser,   // [3:0] kind
	output logic       m_tlast
);
	import tlae_pkg::*;

	localparam int LAW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
	localparam int EAW = (ESCAPE_CAPACITY > 1) ? $clog2(ESCAPE_CAPACITY) : 1;

	emit_t          emit;
	logic           out_free;
	logic           m_tvalid_q;
	kind_t          kind_q;
	logic [7:0]     value_q;
	logic           last_q;

	logic           lwr_en, ewr_en;
	logic [LAW-1:0] lwr_addr, lrd_addr;
	logic [EAW-1:0] ewr_addr, erd_addr;
	logic [7:0]     lwr_data, lrd_data, ewr_data, erd_data;

	assign out_free = !m_tvalid_q || m_tready;

	tlae_ctrl #(
		.LINE_CAPACITY   (LINE_CAPACITY),
		.ESCAPE_CAPACITY (ESCAPE_CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.out_free (out_free),
		.emit     (emit),
		.lwr_en   (lwr_en),
		.lwr_addr (lwr_addr),
		.lwr_data (lwr_data),
		.lrd_addr (lrd_addr),
		.lrd_data (lrd_data),
		.ewr_en   (ewr_en),
		.ewr_addr (ewr_addr),
		.ewr_data (ewr_data),
		.erd_addr (erd_addr),
		.erd_data (erd_data)
	);

	tlae_ram #(
		.WIDTH (8),
		.DEPTH (LINE_CAPACITY)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (lwr_en),
		.wr_addr (lwr_addr),
		.wr_data (lwr_data),
		.rd_addr (lrd_addr),
		.rd_data (lrd_data)
	);

	tlae_ram #(
		.WIDTH (8),
		.DEPTH (ESCAPE_CAPACITY)
	) u_esc_ram (
		.clk     (clk),
		.wr_en   (ewr_en),
		.wr_addr (ewr_addr),
		.wr_data (ewr_data),
		.rd_addr (erd_addr),
		.rd_data (erd_data)
	);

	// Output register parts the sequencer from the downstream request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			kind_q  <= emit.kind;
			value_q <= emit.value;
			last_q  <= emit.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	`TLAE_ASSERT_SAME(a_busy_not_ready, emit.valid, !s_tready, "ready raised while results pending")
	`TLAE_ASSERT_NEXT(a_chain_continues, emit.valid && !emit.last && out_free, emit.valid, "result chain broken before last")
	`TLAE_ASSERT_SAME(a_intr_is_last, m_tvalid && (m_tuser == K_INTR || m_tuser == K_PROMPT), m_tlast, "interrupt or prompt not marked last")

endmodule
